### hdl/abkf_pkg.sv
// shared types, register indexes and the update microprogram of the angle and bias filter
`default_nettype none
package abkf_pkg;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned PcWidth = 5;

  localparam logic [CfgIdxWidth-1:0] RegTimeStep   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegAngleNoise = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegBiasNoise  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegMeasNoise  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegInitAngle  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegInitBias   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    R_RATE, R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11, R_T, R_DP, R_INN, R_S,
    R_K0, R_K1, R_DT, R_QA, R_QB, R_RN, R_MR, R_MA, R_ACC
  } opnd_e;

  typedef struct packed {
    op_e   op;
    opnd_e dst;
    opnd_e a;
    opnd_e b;
  } uop_t;

  localparam logic [PcWidth-1:0] LastPc = 5'd28;

  // predict, then correct; covariance is updated in place in an order that
  // keeps every prior entry alive until its last use; the angle variance
  // term is summed unsaturated in the wide accumulator and clamped once
  function automatic uop_t ucode(input logic [PcWidth-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = '{OP_SUB, R_RATE, R_MR,   R_BIAS};
      5'd1:  u = '{OP_MUL, R_T,    R_RATE, R_DT};
      5'd2:  u = '{OP_ADD, R_ANG,  R_ANG,  R_T};
      5'd3:  u = '{OP_MUL, R_DP,   R_DT,   R_P11};
      5'd4:  u = '{OP_SUB, R_T,    R_DP,   R_P01};
      5'd5:  u = '{OP_SUB, R_T,    R_ACC,  R_P10};
      5'd6:  u = '{OP_ADD, R_T,    R_ACC,  R_QA};
      5'd7:  u = '{OP_MUL, R_T,    R_DT,   R_T};
      5'd8:  u = '{OP_ADD, R_P00,  R_P00,  R_T};
      5'd9:  u = '{OP_SUB, R_P01,  R_P01,  R_DP};
      5'd10: u = '{OP_SUB, R_P10,  R_P10,  R_DP};
      5'd11: u = '{OP_MUL, R_T,    R_QB,   R_DT};
      5'd12: u = '{OP_ADD, R_P11,  R_P11,  R_T};
      5'd13: u = '{OP_SUB, R_INN,  R_MA,   R_ANG};
      5'd14: u = '{OP_ADD, R_S,    R_P00,  R_RN};
      5'd15: u = '{OP_DIV, R_K0,   R_P00,  R_S};
      5'd16: u = '{OP_DIV, R_K1,   R_P10,  R_S};
      5'd17: u = '{OP_MUL, R_T,    R_K0,   R_INN};
      5'd18: u = '{OP_ADD, R_ANG,  R_ANG,  R_T};
      5'd19: u = '{OP_MUL, R_T,    R_K1,   R_INN};
      5'd20: u = '{OP_ADD, R_BIAS, R_BIAS, R_T};
      5'd21: u = '{OP_MUL, R_T,    R_K1,   R_P00};
      5'd22: u = '{OP_SUB, R_P10,  R_P10,  R_T};
      5'd23: u = '{OP_MUL, R_T,    R_K0,   R_P00};
      5'd24: u = '{OP_SUB, R_P00,  R_P00,  R_T};
      5'd25: u = '{OP_MUL, R_T,    R_K1,   R_P01};
      5'd26: u = '{OP_SUB, R_P11,  R_P11,  R_T};
      5'd27: u = '{OP_MUL, R_T,    R_K0,   R_P01};
      5'd28: u = '{OP_SUB, R_P01,  R_P01,  R_T};
      default: u = '{OP_ADD, R_T,  R_T,    R_T};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### hdl/abkf_if.sv
// stream channels of the filter: sample in, estimates out
`default_nettype none
interface abkf_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] measured_rate;
  logic signed [31:0] measured_angle;
  modport source (output valid, output measured_rate, output measured_angle, input ready);
  modport sink (input valid, input measured_rate, input measured_angle, output ready);
endinterface

interface abkf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;
  logic signed [31:0] corrected_rate;
  modport source (output valid, output angle_estimate, output bias_estimate,
                  output corrected_rate, input ready);
  modport sink (input valid, input angle_estimate, input bias_estimate,
                input corrected_rate, output ready);
endinterface
`default_nettype wire

### hdl/angle_bias_kalman_filter.sv
// two-state angle and gyro bias kalman filter on one shared arithmetic unit
`default_nettype none
// Each gyro and angle sample runs one predict and one correct step of a
// two-state kalman filter and gives one beat of angle, bias and bias-corrected
// rate. A small sequencer walks a 29-step microprogram over one shared
// saturating add/subtract, one multiplier (half-width partial products) and
// a restoring divider (one quotient bit a cycle). The two gain divisions
// take the bulk of each run, and input ready is low while a sample is in
// progress. Configuration must be written only while idle; the block itself
// does not enforce this. Writing the initial angle or bias also loads the
// running estimate.
module angle_bias_kalman_filter #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [abkf_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [abkf_pkg::CfgDataWidth-1:0] cfg_data_i,
  abkf_in_if.sink   in_i,
  abkf_out_if.source out_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned HL = W / 2;
  localparam int unsigned HH = W - HL;
  localparam int unsigned NL = W + F;
  localparam int unsigned MW = (2 * W + 1 > NL) ? 2 * W + 1 : NL;
  localparam int unsigned CW = $clog2(NL + 2);
  localparam int unsigned SHL = (F >= 16) ? F - 16 : 0;
  localparam int unsigned SHR = (F >= 16) ? 0 : 16 - F;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] x);
    if (x > 64'(VMAX)) return VMAX;
    if (x < 64'(VMIN)) return VMIN;
    return W'(x);
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [W-1:0] x);
    logic signed [63:0] e;
    e = 64'(x);
    if (e > 64'sh7fff_ffff) return 32'sh7fff_ffff;
    if (e < -64'sh8000_0000) return 32'sh8000_0000;
    return e[31:0];
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W+1:0] s);
    if (s > (W+2)'(VMAX)) return VMAX;
    if (s < (W+2)'(VMIN)) return VMIN;
    return W'(s);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic signed [W-1:0] mag_sat(input logic [MW-1:0] r, input logic neg);
    logic [MW-1:0] lim;
    lim = MW'(VMAX);
    if (neg) begin
      if (r > lim) return VMIN;
      return -$signed(W'(r));
    end
    if (r >= lim) return VMAX;
    return $signed(W'(r));
  endfunction

  // configuration and state
  logic [15:0] dt_q;
  logic [30:0] qa_q, qb_q, rn_q;
  logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [W-1:0] rate_q, t_q, dp_q, inn_q, s_q, k0_q, k1_q, mr_q, ma_q;
  logic signed [31:0] out_ang_q, out_bias_q, out_rate_q;
  logic out_valid_q;

  abkf_pkg::state_e st_q, st_d;
  logic [abkf_pkg::PcWidth-1:0] pc_q;
  logic [CW-1:0] cnt_q;
  logic [2*W-1:0] prod_q;
  logic [W-1:0] rem_q;
  logic [NL-1:0] num_q, quo_q;

  abkf_pkg::uop_t uop;
  logic signed [W-1:0] opa, opb, dt_w, res;
  logic step_done, in_hs, load_out;

  assign uop = abkf_pkg::ucode(pc_q);
  assign dt_w = sat_w((64'(dt_q) << SHL) >> SHR);
  assign in_hs = in_i.valid && in_i.ready;

  function automatic logic signed [W-1:0] pick(input abkf_pkg::opnd_e o,
      input logic signed [W-1:0] rate, ang, bias, p00, p01, p10, p11, t, dp,
      inn, s, k0, k1, dt, qa, qb, rn, mr, ma);
    logic signed [W-1:0] v;
    unique case (o)
      abkf_pkg::R_RATE: v = rate;
      abkf_pkg::R_ANG:  v = ang;
      abkf_pkg::R_BIAS: v = bias;
      abkf_pkg::R_P00:  v = p00;
      abkf_pkg::R_P01:  v = p01;
      abkf_pkg::R_P10:  v = p10;
      abkf_pkg::R_P11:  v = p11;
      abkf_pkg::R_T:    v = t;
      abkf_pkg::R_DP:   v = dp;
      abkf_pkg::R_INN:  v = inn;
      abkf_pkg::R_S:    v = s;
      abkf_pkg::R_K0:   v = k0;
      abkf_pkg::R_K1:   v = k1;
      abkf_pkg::R_DT:   v = dt;
      abkf_pkg::R_QA:   v = qa;
      abkf_pkg::R_QB:   v = qb;
      abkf_pkg::R_RN:   v = rn;
      abkf_pkg::R_MR:   v = mr;
      abkf_pkg::R_MA:   v = ma;
      default:          v = '0;
    endcase
    return v;
  endfunction

  logic signed [W-1:0] qa_w, qb_w, rn_w;
  assign qa_w = sat_w(64'(qa_q));
  assign qb_w = sat_w(64'(qb_q));
  assign rn_w = sat_w(64'(rn_q));

  assign opa = pick(uop.a, rate_q, ang_q, bias_q, p00_q, p01_q, p10_q, p11_q, t_q, dp_q,
                    inn_q, s_q, k0_q, k1_q, dt_w, qa_w, qb_w, rn_w, mr_q, ma_q);
  assign opb = pick(uop.b, rate_q, ang_q, bias_q, p00_q, p01_q, p10_q, p11_q, t_q, dp_q,
                    inn_q, s_q, k0_q, k1_q, dt_w, qa_w, qb_w, rn_w, mr_q, ma_q);

  // adder: unsaturated wide sum, the accumulator carries it between steps
  logic signed [W+1:0] acc_q, acc_a, acc_s;
  assign acc_a = (uop.a == abkf_pkg::R_ACC) ? acc_q : (W+2)'(opa);
  assign acc_s = (uop.op == abkf_pkg::OP_SUB) ? acc_a - (W+2)'(opb)
                                               : acc_a + (W+2)'(opb);

  // shared multiplier: magnitude times one half of the other magnitude
  logic [W-1:0] xm, ym;
  logic [HH-1:0] mul_b;
  logic [W+HH-1:0] mul_p;
  logic [MW-1:0] mul_r;
  logic [2*W:0] rnd;
  logic div_pos;
  logic [W:0] rem_n;
  logic rem_ge;

  assign xm = mag(opa);
  assign ym = mag(opb);
  assign mul_b = (cnt_q == '0) ? HH'(ym[HL-1:0]) : ym[W-1:HL];
  assign mul_p = (W+HH)'(xm) * (W+HH)'(mul_b);
  assign rnd = {1'b0, prod_q} + ((2*W+1)'(1) << (F - 1));
  assign mul_r = MW'(rnd >> F);
  assign div_pos = !opb[W-1] && (opb != '0);
  assign rem_n = {rem_q, num_q[NL-1]};
  assign rem_ge = rem_n >= {1'b0, opb};

  always_comb begin
    step_done = 1'b0;
    res = '0;
    unique case (uop.op)
      abkf_pkg::OP_ADD: begin
        step_done = 1'b1;
        res = sat_add(acc_s);
      end
      abkf_pkg::OP_SUB: begin
        step_done = 1'b1;
        res = sat_add(acc_s);
      end
      abkf_pkg::OP_MUL: begin
        step_done = (cnt_q == CW'(2));
        res = mag_sat(mul_r, opa[W-1] != opb[W-1]);
      end
      abkf_pkg::OP_DIV: begin
        // a gain over a nonpositive variance is zero
        step_done = !div_pos || (cnt_q == CW'(NL + 1));
        res = div_pos ? mag_sat(MW'(quo_q), opa[W-1]) : '0;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      abkf_pkg::ST_IDLE: if (in_hs) st_d = abkf_pkg::ST_RUN;
      abkf_pkg::ST_RUN:  if (step_done && pc_q == abkf_pkg::LastPc) st_d = abkf_pkg::ST_DONE;
      abkf_pkg::ST_DONE: if (!out_valid_q || out_o.ready) st_d = abkf_pkg::ST_IDLE;
      default:           st_d = abkf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    load_out = 1'b0;
    unique case (st_q)
      abkf_pkg::ST_IDLE: in_i.ready = 1'b1;
      abkf_pkg::ST_RUN:  ;
      abkf_pkg::ST_DONE: load_out = !out_valid_q || out_o.ready;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= abkf_pkg::ST_IDLE;
      pc_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == abkf_pkg::ST_RUN) begin
        if (step_done) begin
          cnt_q <= '0;
          pc_q <= (pc_q == abkf_pkg::LastPc) ? '0 : pc_q + 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // configuration, filter state and covariance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 16'd655;
      qa_q <= 31'd66;
      qb_q <= 31'd197;
      rn_q <= 31'd1966;
      ang_q <= '0;
      bias_q <= '0;
      p00_q <= '0;
      p01_q <= '0;
      p10_q <= '0;
      p11_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          abkf_pkg::RegTimeStep:   dt_q <= cfg_data_i[15:0];
          abkf_pkg::RegAngleNoise: qa_q <= cfg_data_i[30:0];
          abkf_pkg::RegBiasNoise:  qb_q <= cfg_data_i[30:0];
          abkf_pkg::RegMeasNoise:  rn_q <= cfg_data_i[30:0];
          abkf_pkg::RegInitAngle:  ang_q <= sat_w(64'($signed(cfg_data_i)));
          abkf_pkg::RegInitBias:   bias_q <= sat_w(64'($signed(cfg_data_i)));
          default: ;
        endcase
      end
      if (st_q == abkf_pkg::ST_RUN && step_done) begin
        unique case (uop.dst)
          abkf_pkg::R_ANG:  ang_q <= res;
          abkf_pkg::R_BIAS: bias_q <= res;
          abkf_pkg::R_P00:  p00_q <= res;
          abkf_pkg::R_P01:  p01_q <= res;
          abkf_pkg::R_P10:  p10_q <= res;
          abkf_pkg::R_P11:  p11_q <= res;
          default: ;
        endcase
      end
    end
  end

  // scratch registers, arithmetic unit state and output beat
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      mr_q <= sat_w(64'(in_i.measured_rate));
      ma_q <= sat_w(64'(in_i.measured_angle));
    end
    if (st_q == abkf_pkg::ST_RUN) begin
      if (step_done) begin
        unique case (uop.dst)
          abkf_pkg::R_RATE: rate_q <= res;
          abkf_pkg::R_T:    t_q <= res;
          abkf_pkg::R_DP:   dp_q <= res;
          abkf_pkg::R_INN:  inn_q <= res;
          abkf_pkg::R_S:    s_q <= res;
          abkf_pkg::R_K0:   k0_q <= res;
          abkf_pkg::R_K1:   k1_q <= res;
          default: ;
        endcase
        if (uop.op == abkf_pkg::OP_ADD || uop.op == abkf_pkg::OP_SUB) acc_q <= acc_s;
      end
      if (uop.op == abkf_pkg::OP_MUL) begin
        if (cnt_q == '0) prod_q <= (2*W)'(mul_p);
        else if (cnt_q == CW'(1)) prod_q <= prod_q + ((2*W)'(mul_p) << HL);
      end
      if (uop.op == abkf_pkg::OP_DIV) begin
        if (cnt_q == '0) begin
          rem_q <= '0;
          quo_q <= '0;
          num_q <= NL'(mag(opa)) << F;
        end else if (cnt_q <= CW'(NL)) begin
          rem_q <= rem_ge ? W'(rem_n - {1'b0, opb}) : W'(rem_n);
          quo_q <= {quo_q[NL-2:0], rem_ge};
          num_q <= num_q << 1;
        end
      end
    end
    if (load_out) begin
      out_ang_q <= sat_32(ang_q);
      out_bias_q <= sat_32(bias_q);
      out_rate_q <= sat_32(rate_q);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.angle_estimate = out_ang_q;
  assign out_o.bias_estimate = out_bias_q;
  assign out_o.corrected_rate = out_rate_q;

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> (st_q == abkf_pkg::ST_RUN) && (pc_q == '0))
    else $error("accepted sample did not start the microprogram");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != abkf_pkg::ST_IDLE) |-> !in_i.ready)
    else $error("input ready while a sample is in progress");

  a_idle_pc_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == abkf_pkg::ST_IDLE) |-> (pc_q == '0) && (cnt_q == '0))
    else $error("sequencer not at program start while idle");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && (st_q == abkf_pkg::ST_IDLE))
    else $error("output beat not presented after the final step");

endmodule
`default_nettype wire
